[rtl/brp_pkg.sv]
// brp_pkg: shared constants, item-kind codes, the half-sine brightness table
// and the divider control/status types for the breathing PWM generator.
// No dependencies.
`timescale 1ns / 1ps

package brp_pkg;

    // PWM resolution and duty limit
    localparam int STEPS      = 100;
    localparam int CNT_W      = 7;
    localparam int DUTY_W     = 7;
    localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(100);

    // Field widths
    localparam int KIND_W     = 3;
    localparam int MS_W       = 16;
    localparam int DV_W       = 8;
    localparam int PHASE_W    = 16;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 16;

    // Reset value of the breathing period register
    localparam logic [MS_W-1:0] PERIOD_RST = MS_W'(1000);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PULSE_ADV = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET_DUTY  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SET_EN    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PULSE_RST = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RESTART   = 3'd5;

    // Divider handshake
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Half-sine brightness table, indexed by the top four phase bits
    function automatic logic [DUTY_W-1:0] half_sine(input logic [3:0] idx);
        logic [DUTY_W-1:0] v;
        case (idx)
            4'd0:    v = 7'd0;
            4'd1:    v = 7'd5;
            4'd2:    v = 7'd20;
            4'd3:    v = 7'd39;
            4'd4:    v = 7'd59;
            4'd5:    v = 7'd78;
            4'd6:    v = 7'd91;
            4'd7:    v = 7'd98;
            4'd8:    v = 7'd100;
            4'd9:    v = 7'd98;
            4'd10:   v = 7'd91;
            4'd11:   v = 7'd78;
            4'd12:   v = 7'd59;
            4'd13:   v = 7'd39;
            4'd14:   v = 7'd20;
            default: v = 7'd5;
        endcase
        return v;
    endfunction

endpackage

[rtl/brp_div.sv]
// brp_div: bit-serial restoring divider, (elapsed << 16) / period, one
// quotient bit per cycle. Low 16 quotient bits are returned.
// Depends on brp_pkg.
`timescale 1ns / 1ps

module brp_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  brp_pkg::div_ctrl_t        ctrl,
    input  logic [brp_pkg::MS_W-1:0]  elapsed,
    input  logic [brp_pkg::MS_W-1:0]  divisor,
    output brp_pkg::div_stat_t        stat,
    output logic [brp_pkg::PHASE_W-1:0] quotient
);
    import brp_pkg::*;

    localparam int NUM_W = 2 * MS_W;
    localparam int CNT_DW = $clog2(NUM_W);

    logic [NUM_W-1:0]  num_reg, num_next;   // dividend shifts out, quotient shifts in
    logic [MS_W-1:0]   rem_reg, rem_next;
    logic [MS_W-1:0]   dsr_reg, dsr_next;
    logic [CNT_DW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [MS_W:0] trial;
    logic [MS_W:0] diff;
    logic          fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        fits  = (trial >= {1'b0, dsr_reg});
        diff  = trial - {1'b0, dsr_reg};
    end

    // Sequencer
    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start && !busy_reg) begin
            num_next  = {elapsed, {MS_W{1'b0}}};
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[MS_W-1:0] : trial[MS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_DW'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = num_reg[PHASE_W-1:0];

endmodule

[rtl/breathing_pwm_generator.sv]
// Breathing PWM generator: 100-step LED PWM with a half-sine breathing mode.
// A pulse advance runs the bit-serial divider, then the phase update, which
//   loads the output register; every other kind shows its result in the
//   output register on the next cycle. Other kinds are taken one item per
//   cycle while the output drains; a pulse advance blocks new items until its
//   phase update. Reset is synchronous, active low; no clearing pass.
// Depends on brp_pkg and brp_div.
`timescale 1ns / 1ps

module breathing_pwm_generator (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: breathing period in ms
    input  logic                          cfg_we,
    input  logic [brp_pkg::MS_W-1:0]      cfg_wdata,
    // Input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [brp_pkg::S_DATA_W-1:0]  s_tdata,  // delta_ms[15:0], duty_value[23:16],
                                                    // enable_value[24], zero pad
    input  logic [brp_pkg::KIND_W-1:0]    s_tuser,  // kind[2:0]
    // Results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [brp_pkg::M_DATA_W-1:0]  m_tdata   // led_level[0], duty_now[7:1],
                                                    // output_enabled[8], zero pad
);
    import brp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;

    logic [1:0]          state_reg, state_next;
    logic [MS_W-1:0]     period_reg;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic [DUTY_W-1:0]   duty_reg, duty_next;
    logic                en_reg, en_next;
    logic                led_reg, led_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                mvalid_reg, mvalid_next;
    logic [M_DATA_W-1:0] mdata_reg, mdata_next;

    logic [KIND_W-1:0]   kind;
    logic [MS_W-1:0]     elapsed;
    logic [DV_W-1:0]     dv;
    logic                ev;
    logic                accept;
    logic [CNT_W:0]      cnt_inc;
    logic                load_out;

    div_ctrl_t           div_ctrl;
    div_stat_t           div_stat;
    logic [PHASE_W-1:0]  quotient;

    // Field unpacking
    assign kind    = s_tuser;
    assign elapsed = s_tdata[MS_W-1:0];
    assign dv      = s_tdata[MS_W +: DV_W];
    assign ev      = s_tdata[MS_W + DV_W];

    // Take an item only when idle and the output register can drain
    assign s_tready = (state_reg == ST_IDLE) && (!mvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign div_ctrl.start = accept && (kind == KIND_PULSE_ADV);

    brp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .elapsed  (elapsed),
        .divisor  (period_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // Item handling and state update
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        duty_next  = duty_reg;
        en_next    = en_reg;
        led_next   = led_reg;
        phase_next = phase_reg;
        load_out   = 1'b0;
        cnt_inc    = {1'b0, step_reg} + 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    load_out = 1'b1;
                    case (kind)
                        KIND_TICK: begin
                            step_next = (cnt_inc >= (CNT_W+1)'(STEPS)) ? '0
                                                                        : cnt_inc[CNT_W-1:0];
                            led_next  = en_reg && (step_next < duty_reg);
                        end
                        KIND_PULSE_ADV: begin
                            load_out   = 1'b0;
                            state_next = ST_DIV;
                        end
                        KIND_SET_DUTY: begin
                            duty_next = (dv > DV_W'(DUTY_MAX)) ? DUTY_MAX : dv[DUTY_W-1:0];
                        end
                        KIND_SET_EN: begin
                            en_next = ev;
                            if (!ev) begin
                                led_next = 1'b0;
                            end
                        end
                        KIND_PULSE_RST: begin
                            phase_next = '0;
                            duty_next  = half_sine(4'd0);
                        end
                        KIND_RESTART: begin
                            step_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    phase_next = phase_reg + quotient;
                    duty_next  = half_sine(phase_next[PHASE_W-1 -: 4]);
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register
    always_comb begin
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        if (load_out) begin
            mvalid_next = 1'b1;
            mdata_next  = M_DATA_W'({en_next, duty_next, led_next});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            period_reg <= PERIOD_RST;
            step_reg   <= '0;
            duty_reg   <= '0;
            en_reg     <= 1'b1;
            led_reg    <= 1'b0;
            phase_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            duty_reg   <= duty_next;
            en_reg     <= en_next;
            led_reg    <= led_next;
            phase_reg  <= phase_next;
            mvalid_reg <= mvalid_next;
            if (cfg_we) begin
                period_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule
